// ----- sv/assert_macros.svh -----
// Assertion macros used by the checker file era_chk.sv.
// Each macro expects signals named clock and reset in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define ERA_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rational alu check failed");

// consequent must hold in the cycle after the antecedent
`define ERA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rational alu check failed");

`endif

// ----- sv/era_pkg.sv -----
// Shared types, codes and step sequencing for the rational arithmetic unit.
// No dependencies; used by every module of the block.
package era_pkg;

   localparam int ERA_WORD_BITS = 64;

   localparam logic [2:0] OP_ADD  = 3'd0;
   localparam logic [2:0] OP_SUB  = 3'd1;
   localparam logic [2:0] OP_MUL  = 3'd2;
   localparam logic [2:0] OP_DIV  = 3'd3;
   localparam logic [2:0] OP_CMP  = 3'd4;
   localparam logic [2:0] OP_NEG  = 3'd5;
   localparam logic [2:0] OP_NORM = 3'd6;

   localparam logic [1:0] ST_OK  = 2'd0;
   localparam logic [1:0] ST_OVF = 2'd1;
   localparam logic [1:0] ST_DOM = 2'd2;

   localparam logic [1:0] U_GCD = 2'd0;
   localparam logic [1:0] U_DIV = 2'd1;
   localparam logic [1:0] U_MUL = 2'd2;

   localparam int STEP_W = 5;
   typedef logic [STEP_W-1:0] step_type;

   localparam step_type K_CHECK = 5'd0;
   localparam step_type K_YG    = 5'd1;
   localparam step_type K_YN    = 5'd2;
   localparam step_type K_YD    = 5'd3;
   localparam step_type K_AG    = 5'd4;
   localparam step_type K_AB1   = 5'd5;
   localparam step_type K_AD1   = 5'd6;
   localparam step_type K_AMX   = 5'd7;
   localparam step_type K_AMY   = 5'd8;
   localparam step_type K_ADEN  = 5'd9;
   localparam step_type K_ASUM  = 5'd10;
   localparam step_type K_MG1   = 5'd11;
   localparam step_type K_MA1   = 5'd12;
   localparam step_type K_MD1   = 5'd13;
   localparam step_type K_MG2   = 5'd14;
   localparam step_type K_MC1   = 5'd15;
   localparam step_type K_MB1   = 5'd16;
   localparam step_type K_MNUM  = 5'd17;
   localparam step_type K_MDEN  = 5'd18;
   localparam step_type K_CP    = 5'd19;
   localparam step_type K_CQ    = 5'd20;
   localparam step_type K_RG    = 5'd21;
   localparam step_type K_RN    = 5'd22;
   localparam step_type K_RD    = 5'd23;
   localparam step_type K_END   = 5'd24;

   typedef struct packed {
      logic     load;
      logic     go;
      step_type step;
   } era_cmd_type;

   typedef struct packed {
      logic done;
      logic err;
   } era_sts_type;

   function automatic step_type next_step(step_type s, logic [2:0] op);
      step_type n;
      n = K_END;
      unique case (s)
         K_CHECK: begin
            case (op)
               OP_ADD:          n = K_AG;
               OP_SUB, OP_DIV:  n = K_YG;
               OP_MUL:          n = K_MG1;
               OP_CMP:          n = K_CP;
               OP_NEG, OP_NORM: n = K_RG;
               default:         n = K_END;
            endcase
         end
         K_YD:    n = (op == OP_SUB) ? K_AG : K_MG1;
         K_ASUM:  n = K_RG;
         K_MDEN:  n = K_RG;
         K_CQ:    n = K_END;
         K_RD:    n = K_END;
         K_END:   n = K_END;
         default: n = s + step_type'(1);
      endcase
      return n;
   endfunction

endpackage

// ----- sv/era_unit.sv -----
// Shared iterative unit: binary GCD, restoring divide and shift-add multiply,
// one step a cycle on 64-bit magnitudes. Depends on era_pkg.
module era_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         go,
   input  logic [1:0]   uop,
   input  logic [63:0]  opa,
   input  logic [63:0]  opb,
   output logic         done,
   output logic [127:0] res
);
   import era_pkg::*;

   logic        busy_ff;
   logic        done_ff;
   logic [1:0]  mode_ff;
   logic [63:0] hi_ff;
   logic [63:0] lo_ff;
   logic [63:0] dv_ff;
   logic [5:0]  cnt_ff;

   logic [64:0] rs;
   logic [64:0] sum;

   assign rs  = {hi_ff, lo_ff[63]};
   assign sum = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, dv_ff} : 65'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (go) begin
            busy_ff <= 1'b1;
            mode_ff <= uop;
            cnt_ff  <= '0;
            case (uop)
               U_GCD: begin
                  hi_ff <= opa;
                  lo_ff <= opb;
               end
               U_DIV: begin
                  hi_ff <= '0;
                  lo_ff <= opa;
                  dv_ff <= opb;
               end
               default: begin
                  hi_ff <= '0;
                  lo_ff <= opb;
                  dv_ff <= opa;
               end
            endcase
         end else if (busy_ff) begin
            case (mode_ff)
               U_GCD: begin
                  // hi and lo hold u and v; cnt counts common factors of two
                  if (hi_ff == '0) begin
                     lo_ff   <= (lo_ff == '0) ? 64'd1 : (lo_ff << cnt_ff);
                     busy_ff <= 1'b0;
                     done_ff <= 1'b1;
                  end else if (lo_ff == '0) begin
                     lo_ff   <= hi_ff << cnt_ff;
                     busy_ff <= 1'b0;
                     done_ff <= 1'b1;
                  end else if (!hi_ff[0] && !lo_ff[0]) begin
                     hi_ff  <= hi_ff >> 1;
                     lo_ff  <= lo_ff >> 1;
                     cnt_ff <= cnt_ff + 6'd1;
                  end else if (!hi_ff[0]) begin
                     hi_ff <= hi_ff >> 1;
                  end else if (!lo_ff[0]) begin
                     lo_ff <= lo_ff >> 1;
                  end else if (hi_ff >= lo_ff) begin
                     hi_ff <= hi_ff - lo_ff;
                  end else begin
                     lo_ff <= lo_ff - hi_ff;
                  end
               end
               U_DIV: begin
                  if (rs >= {1'b0, dv_ff}) begin
                     hi_ff <= 64'(rs - {1'b0, dv_ff});
                     lo_ff <= {lo_ff[62:0], 1'b1};
                  end else begin
                     hi_ff <= rs[63:0];
                     lo_ff <= {lo_ff[62:0], 1'b0};
                  end
                  cnt_ff <= cnt_ff + 6'd1;
                  if (cnt_ff == 6'd63) begin
                     busy_ff <= 1'b0;
                     done_ff <= 1'b1;
                  end
               end
               default: begin
                  hi_ff  <= sum[64:1];
                  lo_ff  <= {sum[0], lo_ff[63:1]};
                  cnt_ff <= cnt_ff + 6'd1;
                  if (cnt_ff == 6'd63) begin
                     busy_ff <= 1'b0;
                     done_ff <= 1'b1;
                  end
               end
            endcase
         end
      end
   end

   assign done = done_ff;
   assign res  = {hi_ff, lo_ff};

endmodule

// ----- sv/era_ctrl.sv -----
// Controller: walks the step sequence of each operation and raises the result strobe.
// Depends on era_pkg for step codes and the command and status structs.
module era_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [2:0]          req_operation,
   input  era_pkg::era_sts_type sts,
   output era_pkg::era_cmd_type cmd,
   output logic                busy,
   output logic                rsp_valid
);
   import era_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_ISSUE = 2'd1;
   localparam logic [1:0] S_WAIT  = 2'd2;
   localparam logic [1:0] S_RESP  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   step_type   step_ff;
   step_type   step_in;
   logic [2:0] op_ff;
   logic       accept;

   assign accept = start && (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd.load = accept;
      cmd.go   = 1'b0;
      cmd.step = step_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_ISSUE;
               step_in  = K_CHECK;
            end
         end
         S_ISSUE: begin
            if (sts.err || step_ff == K_END) begin
               state_in = S_RESP;
            end else begin
               cmd.go   = 1'b1;
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            if (sts.done) begin
               step_in  = next_step(step_ff, op_ff);
               state_in = S_ISSUE;
            end
         end
         S_RESP: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= K_CHECK;
         op_ff    <= OP_ADD;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         if (accept) begin
            op_ff <= req_operation;
         end
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

endmodule

// ----- sv/era_dp.sv -----
// Datapath: operand and work registers, range checks, signed add and result
// formatting; drives the shared iterative unit. Depends on era_pkg, era_unit.
module era_dp #(
   parameter int WORD_BITS = era_pkg::ERA_WORD_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  era_pkg::era_cmd_type cmd,
   output era_pkg::era_sts_type sts,
   input  logic [2:0]           req_operation,
   input  logic signed [63:0]   req_a_num,
   input  logic [62:0]          req_a_den,
   input  logic signed [63:0]   req_b_num,
   input  logic [62:0]          req_b_den,
   output logic signed [63:0]   rsp_res_num,
   output logic [62:0]          rsp_res_den,
   output logic signed [1:0]    rsp_order,
   output logic [1:0]           rsp_status,
   output logic                 rsp_is_integer
);
   import era_pkg::*;

   localparam logic [63:0] HALF  = 64'd1 << (WORD_BITS - 1);
   localparam logic [63:0] WMAXM = HALF - 64'd1;
   localparam logic [1:0]  ORD_LT = 2'b11;
   localparam logic [1:0]  ORD_EQ = 2'b00;
   localparam logic [1:0]  ORD_GT = 2'b01;

   logic [2:0]  op_ff;
   logic        sa_ff, sb_ff, sx_ff, sy_ff, ps_ff, qs_ff;
   logic [63:0] ma_ff, mb_ff, ad_ff, bd_ff;
   logic [63:0] mx_ff, my_ff, xd_ff, yd_ff;
   logic [63:0] g_ff, t1_ff, t2_ff, t3_ff, t4_ff, pm_ff, qm_ff, ph_ff;
   logic [1:0]  ord_ff;
   logic [1:0]  st_ff;
   logic        imm_ff;

   logic         ugo, udone, is_unit;
   logic [1:0]   uop;
   logic [63:0]  ua, ub, ulo;
   logic [127:0] ures;

   function automatic logic in_word(logic s, logic [63:0] m);
      return s ? (m <= HALF) : (m <= WMAXM);
   endfunction

   function automatic logic is_wmin(logic s, logic [63:0] m);
      return s && (m == HALF);
   endfunction

   function automatic logic prod_ovf(logic [127:0] p, logic neg);
      return p > {64'd0, (neg ? HALF : WMAXM)};
   endfunction

   // operand selection for the shared unit
   always_comb begin
      uop     = U_GCD;
      ua      = '0;
      ub      = '0;
      is_unit = 1'b1;
      unique case (cmd.step)
         K_YG:    begin uop = U_GCD; ua = my_ff; ub = yd_ff; end
         K_YN:    begin uop = U_DIV; ua = my_ff; ub = g_ff;  end
         K_YD:    begin uop = U_DIV; ua = yd_ff; ub = g_ff;  end
         K_AG:    begin uop = U_GCD; ua = xd_ff; ub = yd_ff; end
         K_AB1:   begin uop = U_DIV; ua = xd_ff; ub = g_ff;  end
         K_AD1:   begin uop = U_DIV; ua = yd_ff; ub = g_ff;  end
         K_AMX:   begin uop = U_MUL; ua = mx_ff; ub = t2_ff; end
         K_AMY:   begin uop = U_MUL; ua = my_ff; ub = t1_ff; end
         K_ADEN:  begin uop = U_MUL; ua = t1_ff; ub = yd_ff; end
         K_MG1:   begin uop = U_GCD; ua = mx_ff; ub = yd_ff; end
         K_MA1:   begin uop = U_DIV; ua = mx_ff; ub = g_ff;  end
         K_MD1:   begin uop = U_DIV; ua = yd_ff; ub = g_ff;  end
         K_MG2:   begin uop = U_GCD; ua = my_ff; ub = xd_ff; end
         K_MC1:   begin uop = U_DIV; ua = my_ff; ub = g_ff;  end
         K_MB1:   begin uop = U_DIV; ua = xd_ff; ub = g_ff;  end
         K_MNUM:  begin uop = U_MUL; ua = t1_ff; ub = t3_ff; end
         K_MDEN:  begin uop = U_MUL; ua = t4_ff; ub = t2_ff; end
         K_CP:    begin uop = U_MUL; ua = mx_ff; ub = yd_ff; end
         K_CQ:    begin uop = U_MUL; ua = my_ff; ub = xd_ff; end
         K_RG:    begin uop = U_GCD; ua = mx_ff; ub = xd_ff; end
         K_RN:    begin uop = U_DIV; ua = mx_ff; ub = g_ff;  end
         K_RD:    begin uop = U_DIV; ua = xd_ff; ub = g_ff;  end
         default: is_unit = 1'b0;
      endcase
   end

   assign ugo = cmd.go && is_unit;

   era_unit u_unit (
      .clock (clock),
      .reset (reset),
      .go    (ugo),
      .uop   (uop),
      .opa   (ua),
      .opb   (ub),
      .done  (udone),
      .res   (ures)
   );

   assign ulo = ures[63:0];

   // operand screening
   logic uses_b, dom_err, rng_err, wmin_err;
   always_comb begin
      uses_b   = (op_ff <= OP_CMP);
      dom_err  = (op_ff > OP_NORM) || (ad_ff == '0) || (uses_b && bd_ff == '0) ||
                 (op_ff == OP_DIV && mb_ff == '0);
      rng_err  = !in_word(sa_ff, ma_ff) || (ad_ff > WMAXM) ||
                 (uses_b && (!in_word(sb_ff, mb_ff) || bd_ff > WMAXM));
      wmin_err = ((op_ff == OP_SUB || op_ff == OP_DIV) && is_wmin(sb_ff, mb_ff)) ||
                 ((op_ff == OP_NEG || op_ff == OP_NORM) && is_wmin(sa_ff, ma_ff));
   end

   // signed add of the two cross terms
   logic [64:0] sum65;
   logic [63:0] add_mag;
   logic        add_neg, add_ovf;
   always_comb begin
      sum65   = {1'b0, pm_ff} + {1'b0, qm_ff};
      add_ovf = 1'b0;
      if (ps_ff == qs_ff) begin
         add_mag = sum65[63:0];
         add_neg = ps_ff;
         add_ovf = sum65 > {1'b0, (ps_ff ? HALF : WMAXM)};
      end else if (pm_ff >= qm_ff) begin
         add_mag = pm_ff - qm_ff;
         add_neg = ps_ff;
      end else begin
         add_mag = qm_ff - pm_ff;
         add_neg = qs_ff;
      end
      if (add_mag == '0) add_neg = 1'b0;
   end

   // exact compare: sign class 0 negative, 1 zero, 2 positive
   logic [1:0] ca, cb, cmp_ord, mag_ord;
   always_comb begin
      ca = (mx_ff == '0) ? 2'd1 : (sx_ff ? 2'd0 : 2'd2);
      cb = (my_ff == '0) ? 2'd1 : (sy_ff ? 2'd0 : 2'd2);
      if ({ph_ff, pm_ff} < ures)      mag_ord = ORD_LT;
      else if ({ph_ff, pm_ff} > ures) mag_ord = ORD_GT;
      else                            mag_ord = ORD_EQ;
      if (ca != cb)        cmp_ord = (ca < cb) ? ORD_LT : ORD_GT;
      else if (ca == 2'd1) cmp_ord = ORD_EQ;
      else if (ca == 2'd0) cmp_ord = 2'(-mag_ord);
      else                 cmp_ord = mag_ord;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= ST_OK;
         ord_ff <= ORD_EQ;
         imm_ff <= 1'b0;
      end else begin
         imm_ff <= cmd.go && !is_unit;
         if (cmd.load) begin
            op_ff  <= req_operation;
            sa_ff  <= req_a_num[63];
            ma_ff  <= req_a_num[63] ? (64'd0 - $unsigned(req_a_num)) : $unsigned(req_a_num);
            ad_ff  <= {1'b0, req_a_den};
            sb_ff  <= req_b_num[63];
            mb_ff  <= req_b_num[63] ? (64'd0 - $unsigned(req_b_num)) : $unsigned(req_b_num);
            bd_ff  <= {1'b0, req_b_den};
            st_ff  <= ST_OK;
            ord_ff <= ORD_EQ;
         end
         if (cmd.go) begin
            case (cmd.step)
               K_CHECK: begin
                  if (dom_err) st_ff <= ST_DOM;
                  else if (rng_err || wmin_err) st_ff <= ST_OVF;
                  sx_ff <= (op_ff == OP_NEG) ? (ma_ff != '0 && !sa_ff) : sa_ff;
                  mx_ff <= ma_ff;
                  xd_ff <= ad_ff;
                  if (op_ff == OP_SUB) begin
                     sy_ff <= (mb_ff != '0) && !sb_ff;
                     my_ff <= mb_ff;
                     yd_ff <= bd_ff;
                  end else if (op_ff == OP_DIV) begin
                     // reciprocal of b
                     sy_ff <= sb_ff;
                     my_ff <= bd_ff;
                     yd_ff <= mb_ff;
                  end else begin
                     sy_ff <= sb_ff;
                     my_ff <= mb_ff;
                     yd_ff <= bd_ff;
                  end
               end
               K_ASUM: begin
                  if (add_ovf) st_ff <= ST_OVF;
                  sx_ff <= add_neg;
                  mx_ff <= add_mag;
                  xd_ff <= t3_ff;
               end
               K_RG: begin
                  if (is_wmin(sx_ff, mx_ff)) st_ff <= ST_OVF;
               end
               default: ;
            endcase
         end
         if (udone) begin
            case (cmd.step)
               K_YG, K_AG, K_MG1, K_MG2, K_RG: g_ff <= ulo;
               K_YN: begin
                  my_ff <= ulo;
                  sy_ff <= sy_ff && (ulo != '0);
               end
               K_YD, K_MD1: begin
                  if (cmd.step == K_YD) yd_ff <= ulo;
                  else t2_ff <= ulo;
               end
               K_AB1, K_MA1: t1_ff <= ulo;
               K_AD1: t2_ff <= ulo;
               K_MC1: t3_ff <= ulo;
               K_MB1: t4_ff <= ulo;
               K_AMX: begin
                  pm_ff <= ulo;
                  ps_ff <= sx_ff && (ulo != '0);
                  if (prod_ovf(ures, sx_ff)) st_ff <= ST_OVF;
               end
               K_AMY: begin
                  qm_ff <= ulo;
                  qs_ff <= sy_ff && (ulo != '0);
                  if (prod_ovf(ures, sy_ff)) st_ff <= ST_OVF;
               end
               K_ADEN: begin
                  t3_ff <= ulo;
                  if (prod_ovf(ures, 1'b0)) st_ff <= ST_OVF;
               end
               K_MNUM: begin
                  mx_ff <= ulo;
                  sx_ff <= (sx_ff ^ sy_ff) && (ures != '0);
                  if (prod_ovf(ures, sx_ff ^ sy_ff)) st_ff <= ST_OVF;
               end
               K_MDEN: begin
                  xd_ff <= ulo;
                  if (prod_ovf(ures, 1'b0)) st_ff <= ST_OVF;
               end
               K_CP: begin
                  ph_ff <= ures[127:64];
                  pm_ff <= ulo;
               end
               K_CQ: ord_ff <= cmp_ord;
               K_RN: begin
                  mx_ff <= ulo;
                  sx_ff <= sx_ff && (ulo != '0);
               end
               K_RD: xd_ff <= ulo;
               default: ;
            endcase
         end
      end
   end

   assign sts.done = udone || imm_ff;
   assign sts.err  = (st_ff != ST_OK);

   logic ok, val;
   assign ok  = (st_ff == ST_OK);
   assign val = ok && (op_ff != OP_CMP);

   assign rsp_res_num    = val ? $signed(sx_ff ? (64'd0 - mx_ff) : mx_ff) : 64'sd0;
   assign rsp_res_den    = val ? xd_ff[62:0] : 63'd0;
   assign rsp_is_integer = val && (xd_ff == 64'd1);
   assign rsp_order      = ok ? $signed(ord_ff) : 2'sd0;
   assign rsp_status     = st_ff;

endmodule

// ----- sv/exact_rational_alu.sv -----
// Exact rational ALU: add, subtract, multiply, divide, compare, negate or
// normalise two fractions, result reduced to lowest terms. An item is taken
// when start is high and busy is low; busy stays high until the result
// strobe rsp_valid, which lasts one cycle and cannot be held off. One item is
// worked at a time. Its length is set by the shared iterative unit, which
// runs a binary GCD, a restoring divide or a shift-add multiply for each step
// that uses it, and by the issue and wait states that the controller spends
// on each step. Subtract and divide add one reduction of b.
// Errors found while screening the operands end the item before the shared
// unit is started.
// Depends on era_pkg, era_ctrl, era_dp.
module exact_rational_alu #(
   parameter int WORD_BITS = era_pkg::ERA_WORD_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_operation,
   input  logic signed [63:0] req_a_num,
   input  logic [62:0]        req_a_den,
   input  logic signed [63:0] req_b_num,
   input  logic [62:0]        req_b_den,
   output logic               rsp_valid,
   output logic signed [63:0] rsp_res_num,
   output logic [62:0]        rsp_res_den,
   output logic signed [1:0]  rsp_order,
   output logic [1:0]         rsp_status,
   output logic               rsp_is_integer
);
   import era_pkg::*;

   era_cmd_type cmd;
   era_sts_type sts;

   era_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_operation (req_operation),
      .sts           (sts),
      .cmd           (cmd),
      .busy          (busy),
      .rsp_valid     (rsp_valid)
   );

   era_dp #(.WORD_BITS(WORD_BITS)) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_operation  (req_operation),
      .req_a_num      (req_a_num),
      .req_a_den      (req_a_den),
      .req_b_num      (req_b_num),
      .req_b_den      (req_b_den),
      .rsp_res_num    (rsp_res_num),
      .rsp_res_den    (rsp_res_den),
      .rsp_order      (rsp_order),
      .rsp_status     (rsp_status),
      .rsp_is_integer (rsp_is_integer)
   );

endmodule

// ----- sv/era_chk.sv -----
// Port-level checker for exact_rational_alu, bound to the top level.
// Depends on era_pkg and assert_macros.svh.
`include "assert_macros.svh"

module era_chk (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input logic [62:0]       rsp_res_den,
   input logic signed [1:0] rsp_order,
   input logic [1:0]        rsp_status,
   input logic              rsp_is_integer
);
   import era_pkg::*;

   `ERA_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
   `ERA_ASSERT_NEXT(a_strobe_ends, rsp_valid, !busy && !rsp_valid)
   `ERA_ASSERT_SAME(a_strobe_busy, rsp_valid, busy)
   `ERA_ASSERT_SAME(a_err_clear, rsp_valid && rsp_status != ST_OK, rsp_res_den == '0 && !rsp_is_integer && rsp_order == 2'sd0)
   `ERA_ASSERT_SAME(a_int_den, rsp_valid && rsp_is_integer, rsp_res_den == 63'd1)

endmodule

bind exact_rational_alu era_chk u_era_chk (.*);

// ----- test/tb_exact_rational_alu.sv -----
// Self-checking testbench for exact_rational_alu: directed and random items,
// checked against a built-in predictor of reduced rational results.
// Depends on era_pkg and the exact_rational_alu RTL.
module tb_exact_rational_alu;
   import era_pkg::*;

   typedef logic signed [129:0] wide_type;

   typedef struct {
      logic signed [63:0] num;
      logic [62:0]        den;
      logic signed [1:0]  order;
      logic [1:0]         status;
      logic               is_int;
   } quotient_type;

   localparam wide_type WMAX = (wide_type'(1) <<< 63) - 1;
   localparam wide_type WMIN = -(wide_type'(1) <<< 63);
   localparam int       IDLE_LIMIT = 10000;

   class rational_board;
      quotient_type expected_q[$];
      int           errors;

      function logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
         logic [63:0] t;
         while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
         end
         return (x == 0) ? 64'd1 : x;
      endfunction

      function wide_type mag(wide_type v);
         return (v < 0) ? -v : v;
      endfunction

      function bit fits(wide_type v);
         return v >= WMIN && v <= WMAX;
      endfunction

      function logic [1:0] lowest(wide_type n, wide_type d,
                                  output wide_type rn, output wide_type rd);
         wide_type g;
         rn = 0;
         rd = 0;
         if (d == 0) return ST_DOM;
         if (n == WMIN || !fits(n) || d > WMAX) return ST_OVF;
         g = wide_type'(gcd64(64'(mag(n)), 64'(d)));
         rn = n / g;
         rd = d / g;
         return ST_OK;
      endfunction

      function logic [1:0] sum_of(wide_type an, wide_type ad, wide_type bn, wide_type bd,
                                  output wide_type rn, output wide_type rd);
         wide_type g, x, y, s, dn;
         rn = 0;
         rd = 0;
         g  = wide_type'(gcd64(64'(ad), 64'(bd)));
         x  = an * (bd / g);
         y  = bn * (ad / g);
         s  = x + y;
         dn = (ad / g) * bd;
         if (!fits(x) || !fits(y) || !fits(s) || !fits(dn)) return ST_OVF;
         return lowest(s, dn, rn, rd);
      endfunction

      function logic [1:0] product_of(wide_type an, wide_type ad, wide_type bn,
                                      wide_type bd,
                                      output wide_type rn, output wide_type rd);
         wide_type g1, g2, pn, pd;
         rn = 0;
         rd = 0;
         g1 = wide_type'(gcd64(64'(mag(an)), 64'(bd)));
         g2 = wide_type'(gcd64(64'(mag(bn)), 64'(ad)));
         pn = (an / g1) * (bn / g2);
         pd = (ad / g2) * (bd / g1);
         if (!fits(pn) || !fits(pd)) return ST_OVF;
         return lowest(pn, pd, rn, rd);
      endfunction

      function void note(logic [2:0] op, logic signed [63:0] an_i, logic [62:0] ad_i,
                         logic signed [63:0] bn_i, logic [62:0] bd_i);
         wide_type an, ad, bn, bd, rn, rd, tn, td, p, q;
         logic [1:0] st;
         logic signed [1:0] ord;
         quotient_type e;
         an = wide_type'(an_i);
         ad = wide_type'(ad_i);
         bn = wide_type'(bn_i);
         bd = wide_type'(bd_i);
         rn = 0; rd = 0; ord = 0; st = ST_OK;
         if (op > OP_NORM || ad == 0 || (op <= OP_CMP && bd == 0)) st = ST_DOM;
         else if (op == OP_DIV && bn == 0) st = ST_DOM;
         else begin
            case (op)
               OP_ADD: st = sum_of(an, ad, bn, bd, rn, rd);
               OP_SUB: begin
                  if (bn == WMIN) st = ST_OVF;
                  else begin
                     st = lowest(-bn, bd, tn, td);
                     if (st == ST_OK) st = sum_of(an, ad, tn, td, rn, rd);
                  end
               end
               OP_MUL: st = product_of(an, ad, bn, bd, rn, rd);
               OP_DIV: begin
                  // reciprocal of b reduced first, sign kept on its numerator
                  if (bn == WMIN) st = ST_OVF;
                  else begin
                     st = lowest((bn < 0) ? -bd : bd, mag(bn), tn, td);
                     if (st == ST_OK) st = product_of(an, ad, tn, td, rn, rd);
                  end
               end
               OP_CMP: begin
                  p = an * bd;
                  q = bn * ad;
                  ord = (p < q) ? -2'sd1 : (p > q) ? 2'sd1 : 2'sd0;
               end
               OP_NEG: st = (an == WMIN) ? ST_OVF : lowest(-an, ad, rn, rd);
               default: st = lowest(an, ad, rn, rd);
            endcase
         end
         if (st != ST_OK || op == OP_CMP) begin
            rn = 0;
            rd = 0;
         end
         if (st != ST_OK) ord = 0;
         e.num    = rn[63:0];
         e.den    = rd[62:0];
         e.order  = ord;
         e.status = st;
         e.is_int = (st == ST_OK && op != OP_CMP && rd == 1);
         expected_q.push_back(e);
      endfunction

      task report(string what, logic [63:0] got, logic [63:0] want);
         $display("mismatch on %s: got %h expected %h", what, got, want);
         errors++;
      endtask

      task check(quotient_type r);
         quotient_type e;
         if (expected_q.size() == 0) begin
            report("unexpected result", r.num, 64'd0);
            return;
         end
         e = expected_q.pop_front();
         if (r.num !== e.num) report("res_num", r.num, e.num);
         if (r.den !== e.den) report("res_den", 64'(r.den), 64'(e.den));
         if (r.order !== e.order) report("order", 64'(r.order), 64'(e.order));
         if (r.status !== e.status) report("status", 64'(r.status), 64'(e.status));
         if (r.is_int !== e.is_int) report("is_integer", 64'(r.is_int), 64'(e.is_int));
      endtask
   endclass

   logic               clock, reset, start, busy, rsp_valid, rsp_is_integer;
   logic [2:0]         req_operation;
   logic signed [63:0] req_a_num, req_b_num, rsp_res_num;
   logic [62:0]        req_a_den, req_b_den, rsp_res_den;
   logic signed [1:0]  rsp_order;
   logic [1:0]         rsp_status;

   rational_board board = new();
   int idle_cycles = 0;

   exact_rational_alu DUT (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      quotient_type r;
      if (!reset && rsp_valid) begin
         r.num = rsp_res_num; r.den = rsp_res_den; r.order = rsp_order;
         r.status = rsp_status; r.is_int = rsp_is_integer;
         board.check(r);
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // drive one item and hold it until the block takes it
   task send(logic [2:0] op, logic signed [63:0] an, logic [62:0] ad,
             logic signed [63:0] bn, logic [62:0] bd);
      req_operation <= op;
      req_a_num <= an; req_a_den <= ad; req_b_num <= bn; req_b_den <= bd;
      start <= 1;
      do @(posedge clock); while (busy);
      board.note(op, an, ad, bn, bd);
   endtask

   function logic signed [63:0] any_num();
      case ($urandom_range(0, 9))
         0: return {$urandom, $urandom};
         1: case ($urandom_range(0, 4))
               0: return 64'sh8000_0000_0000_0000;
               1: return 64'sh7fff_ffff_ffff_ffff;
               2: return 0;
               3: return 1;
               default: return -1;
            endcase
         2, 3: return 64'($signed($urandom));
         default: return $signed(64'($urandom_range(0, 2000))) - 64'sd1000;
      endcase
   endfunction

   function logic [62:0] any_den();
      case ($urandom_range(0, 29))
         0: return 0;
         1, 2: return 63'({$urandom, $urandom} >> 1);
         3: return '1;
         4, 5, 6: return 63'($urandom);
         default: return 63'($urandom_range(1, 1000));
      endcase
   endfunction

   localparam logic signed [63:0] WMIN64 = 64'sh8000_0000_0000_0000;
   localparam logic signed [63:0] WMAX64 = 64'sh7fff_ffff_ffff_ffff;

   initial begin
      int burst;
      int gap;
      logic [2:0] op;
      reset = 1; start = 0; req_operation = 0;
      req_a_num = 0; req_a_den = 0; req_b_num = 0; req_b_den = 0;
      burst = 0;
      repeat (8) @(posedge clock);
      reset <= 0;
      send(OP_ADD, 1, 2, 1, 3);
      send(OP_SUB, 3, 4, -5, 6);
      send(OP_MUL, -6, 35, 14, 15);
      send(OP_DIV, 2, 3, -4, 9);
      send(OP_CMP, 1, 3, 2, 6);
      send(OP_CMP, -7, 2, 5, 1);
      send(OP_CMP, WMAX64, '1, WMIN64, 1);
      send(OP_NEG, -5, 10, 0, 0);
      send(OP_NORM, 6, 4, 0, 0);
      send(OP_NORM, -12, 8, 0, 0);
      send(3'd7, 1, 1, 1, 1);
      send(OP_ADD, 1, 0, 1, 1);
      send(OP_MUL, 1, 1, 1, 0);
      send(OP_DIV, 1, 2, 0, 5);
      send(OP_NEG, WMIN64, 1, 0, 0);
      send(OP_SUB, 1, 1, WMIN64, 1);
      send(OP_DIV, 1, 1, WMIN64, 3);
      send(OP_NORM, WMIN64, 1, 0, 0);
      send(OP_MUL, WMAX64, 1, 2, 1);
      send(OP_ADD, WMAX64, 1, 1, 1);
      send(OP_ADD, WMIN64, 1, WMAX64, 1);
      send(OP_MUL, WMAX64, '1, '1, '1);
      send(OP_SUB, 0, '1, 0, 1);
      send(OP_NEG, 0, 7, 0, 0);
      for (int i = 0; i < 1300; i++) begin
         op = ($urandom_range(0, 40) == 0) ? 3'd7 : 3'($urandom_range(0, 6));
         send(op, any_num(), any_den(), any_num(), any_den());
         if (burst > 0) burst--;
         else begin
            burst = $urandom_range(0, 7);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            // a gap of zero keeps start high into the next item
            if (gap > 0) begin
               start <= 0;
               repeat (gap) @(posedge clock);
            end
         end
      end
      start <= 0;
      while (board.expected_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (board.errors == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end
endmodule
